>>> sv/ppt_pkg.sv
// Package with the shared constants, codes and types of the point-in-polygon tester.
`default_nettype none
package ppt_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 24;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  // Differences of two coordinates need one more bit, their products twice that.
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ppt_state_t;

  typedef struct packed {
    logic accept;
    logic start_scan;
    logic issue;
    logic out_load;
  } ppt_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic pipe_busy;
  } ppt_stat_t;

endpackage
`default_nettype wire

>>> sv/ppt_if.sv
// Handshake interfaces of the input item channel and the result channel.
`default_nettype none
interface ppt_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              operation;
  logic signed [ppt_pkg::COORD_BITS-1:0]   coord_x;
  logic signed [ppt_pkg::COORD_BITS-1:0]   coord_y;

  modport source (output valid, operation, coord_x, coord_y, input ready);
  modport sink   (input valid, operation, coord_x, coord_y, output ready);
endinterface

interface ppt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         inside_res;
  logic                         status;
  logic [ppt_pkg::CNT_W-1:0]    vertex_total;

  modport source (output valid, inside_res, status, vertex_total, input ready);
  modport sink   (input valid, inside_res, status, vertex_total, output ready);
endinterface
`default_nettype wire

>>> sv/ppt_ctrl.sv
// Controller state machine: sequences item acceptance, the edge scan and result hand-off.
`default_nettype none
module ppt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_operation,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire ppt_pkg::ppt_stat_t stat,
  output ppt_pkg::ppt_cmd_t       cmd
);
  import ppt_pkg::*;

  ppt_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_operation == OP_QUERY && !stat.count_zero) begin
            cmd.start_scan = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A waiting result leaves on its transfer unless a new one replaces it.
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !stat.pipe_busy)
    else $error("edge pipeline still busy while idle");

  a_last_read_once: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && stat.scan_last) |=> !cmd.issue)
    else $error("vertex reads continue past the closing edge");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r != ST_IDLE))
    else $error("second item taken before the first is finished");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not offered");

endmodule
`default_nettype wire

>>> sv/ppt_dp.sv
// Datapath: vertex memory, count, edge-crossing pipeline and result register.
`default_nettype none
module ppt_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic [1:0]                             in_operation,
  input  wire logic signed [ppt_pkg::COORD_BITS-1:0]  in_coord_x,
  input  wire logic signed [ppt_pkg::COORD_BITS-1:0]  in_coord_y,
  input  wire ppt_pkg::ppt_cmd_t                      cmd,
  output ppt_pkg::ppt_stat_t                          stat,
  output logic                                        out_inside_res,
  output logic                                        out_status,
  output logic [ppt_pkg::CNT_W-1:0]                   out_vertex_total
);
  import ppt_pkg::*;

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  logic [CNT_W-1:0]             count_r;
  logic                         full;
  logic                         status_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic [ADDR_W-1:0]            addr_r, last_addr_r;
  logic                         first_r;

  // Stage 1: registered memory read; vertex i, with vertex j held from the read before.
  logic                         s1_v_r, s1_first_r;
  logic signed [COORD_BITS-1:0] rd_x_r, rd_y_r, prev_x_r, prev_y_r;
  // Stage 2: differences.
  logic                         s2_v_r, s2_straddle_r, s2_dypos_r;
  logic signed [DIFF_W-1:0]     s2_a_r, s2_dy_r, s2_c_r, s2_d_r;
  // Stage 3: products.
  logic                         s3_v_r, s3_straddle_r, s3_dypos_r;
  logic signed [PROD_W-1:0]     s3_ad_r, s3_cd_r;

  logic                         inside_r, inside_nxt;
  logic                         hit;

  logic                         out_inside_r, out_status_r;
  logic [CNT_W-1:0]             out_total_r;

  assign full = (count_r == CNT_W'(MAX_VERTICES));

  // Item acceptance: clear and append act on the store at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.accept) begin
      case (in_operation)
        OP_CLEAR:  count_r <= '0;
        OP_APPEND: if (!full) count_r <= count_r + CNT_W'(1);
        default:   count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_operation == OP_APPEND && !full) begin
      mem_x[count_r[ADDR_W-1:0]] <= in_coord_x;
      mem_y[count_r[ADDR_W-1:0]] <= in_coord_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_x_r <= mem_x[addr_r];
    rd_y_r <= mem_y[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r     <= in_coord_x;
      py_r     <= in_coord_y;
      status_r <= (in_operation == OP_APPEND) && full;
    end
  end

  // Read order: the last vertex first, to close the polygon, then vertices 0 to n-1.
  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      addr_r      <= ADDR_W'(count_r - CNT_W'(1));
      last_addr_r <= ADDR_W'(count_r - CNT_W'(1));
      first_r     <= 1'b1;
    end else if (cmd.issue) begin
      addr_r  <= first_r ? '0 : addr_r + ADDR_W'(1);
      first_r <= 1'b0;
    end
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.scan_last  = !first_r && (addr_r == last_addr_r);
  assign stat.pipe_busy  = s1_v_r || s2_v_r || s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r && !s1_first_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= first_r;
    if (s1_v_r) begin
      prev_x_r      <= rd_x_r;
      prev_y_r      <= rd_y_r;
      s2_straddle_r <= (rd_y_r > py_r) != (prev_y_r > py_r);
      s2_dypos_r    <= prev_y_r > rd_y_r;
      s2_a_r        <= DIFF_W'(px_r) - DIFF_W'(rd_x_r);
      s2_dy_r       <= DIFF_W'(prev_y_r) - DIFF_W'(rd_y_r);
      s2_c_r        <= DIFF_W'(prev_x_r) - DIFF_W'(rd_x_r);
      s2_d_r        <= DIFF_W'(py_r) - DIFF_W'(rd_y_r);
    end
  end

  always_ff @(posedge clk) begin
    s3_straddle_r <= s2_straddle_r;
    s3_dypos_r    <= s2_dypos_r;
    s3_ad_r       <= PROD_W'(s2_a_r) * PROD_W'(s2_dy_r);
    s3_cd_r       <= PROD_W'(s2_c_r) * PROD_W'(s2_d_r);
  end

  // Cross-multiplied form of the crossing compare; the sense flips when dy is negative.
  assign hit = s3_dypos_r ? (s3_ad_r < s3_cd_r) : (s3_cd_r < s3_ad_r);

  always_comb begin
    inside_nxt = inside_r;
    if (cmd.accept) begin
      inside_nxt = 1'b0;
    end else if (s3_v_r && s3_straddle_r && hit) begin
      inside_nxt = !inside_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_inside_r <= inside_r;
      out_status_r <= status_r;
      out_total_r  <= count_r;
    end
  end

  assign out_inside_res   = out_inside_r;
  assign out_status       = out_status_r;
  assign out_vertex_total = out_total_r;

endmodule
`default_nettype wire

>>> sv/point_in_polygon_test_top.sv
// Top level of the point-in-polygon tester: controller, datapath and channel wiring.
//
// Items arrive on in_ch (operation, coord_x, coord_y) and each one gives exactly one
// result on out_ch (inside_res, status, vertex_total); a transfer happens when valid
// and ready are both high. Operation clear empties the vertex store, append adds a
// vertex (status 1 and no change when the store already holds 256), query tests the
// point against the closed polygon by the even-odd crossing rule.
// A query over n stored vertices makes n + 1 reads to close the polygon, the single
// read port of the vertex memory yielding one vertex a cycle, and a difference,
// multiply and compare pipeline follows. A query with no vertices skips the scan.
// One item is worked on at a time; in_ch.ready is high only while idle.
// The result sits in an output register, so the next item is taken while it waits;
// if the receiver stalls, the following result waits in the controller until the
// register is free. Reset empties the store and drops any pending result; the
// memory contents are not cleared, only entries below the count are ever read.
`default_nettype none
module point_in_polygon_test_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ppt_in_if.sink      in_ch,
  ppt_out_if.source   out_ch
);
  import ppt_pkg::*;

  ppt_cmd_t  cmd;
  ppt_stat_t stat;

  ppt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  ppt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_ch.operation),
    .in_coord_x       (in_ch.coord_x),
    .in_coord_y       (in_ch.coord_y),
    .cmd              (cmd),
    .stat             (stat),
    .out_inside_res   (out_ch.inside_res),
    .out_status       (out_ch.status),
    .out_vertex_total (out_ch.vertex_total)
  );

endmodule
`default_nettype wire

>>> tb/point_in_polygon_test_top_test.sv
// Self-checking testbench of the point-in-polygon tester: directed cases, a full store, random polygons.
`timescale 1ns / 100ps
module point_in_polygon_test_top_test;
  import ppt_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic             inside_res;
    logic             status;
    logic [CNT_W-1:0] vertex_total;
  } verdict_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_PATTERN, RX_LONG} rx_mode_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 3_000_000;

  logic clk = 1'b0;
  logic rst_n;

  ppt_in_if  in_ch();
  ppt_out_if out_ch();

  point_in_polygon_test_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  // Predicted polygon store and the verdicts still owed by the block.
  coord_t      poly_x [MAX_VERTICES];
  coord_t      poly_y [MAX_VERTICES];
  int unsigned poly_count = 0;
  verdict_t    expected_verdicts[$];

  int failures        = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int random_items    = 0;
  int cycle_count     = 0;

  // Sender burst control.
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  // Even-odd crossing test over the predicted store. Both sides of the crossing
  // comparison are scaled by the edge's dy, so the sense flips when dy is negative.
  function automatic logic crossing_parity(coord_t px, coord_t py);
    longint xi, yi, xj, yj, dy, pxl, pyl;
    logic   parity;
    logic   hit;
    int     i, j;
    parity = 1'b0;
    pxl = px;
    pyl = py;
    if (poly_count == 0) return 1'b0;
    j = poly_count - 1;
    for (i = 0; i < poly_count; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi > pyl) != (yj > pyl)) begin
        dy = yj - yi;
        if (dy > 0) hit = ((pxl - xi) * dy) < ((xj - xi) * (pyl - yi));
        else hit = ((xj - xi) * (pyl - yi)) < ((pxl - xi) * dy);
        if (hit) parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  function automatic verdict_t predict_verdict(logic [1:0] op, coord_t x, coord_t y);
    verdict_t v;
    v = '0;
    case (op)
      OP_CLEAR: poly_count = 0;
      OP_APPEND: begin
        if (poly_count < MAX_VERTICES) begin
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          poly_count++;
        end else begin
          v.status = 1'b1;
        end
      end
      OP_QUERY: v.inside_res = crossing_parity(x, y);
      default: ;
    endcase
    v.vertex_total = CNT_W'(poly_count);
    return v;
  endfunction

  // Drives one item at the falling edge and waits for its transfer.
  task automatic send_item(input logic [1:0] op, input coord_t x, input coord_t y);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.coord_x   <= x;
    in_ch.coord_y   <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_verdicts.push_back(predict_verdict(op, x, y));
    items_sent++;
  endtask

  function automatic coord_t near_coord(coord_t centre, int span);
    return coord_t'(int'(centre) + $urandom_range(0, 2 * span) - span);
  endfunction

  task automatic test_sparse_store();
    send_item(OP_QUERY, 5, 5);
    send_item(OP_UNUSED, -1, -1);
    send_item(OP_APPEND, 0, 0);
    send_item(OP_QUERY, -3, 0);
    send_item(OP_APPEND, 10, 20);
    send_item(OP_QUERY, 1, 10);
    send_item(OP_CLEAR, COORD_MAX, COORD_MIN);
    send_item(OP_QUERY, 0, 0);
  endtask

  // A square spanning the whole coordinate range, queried on and inside its edges.
  task automatic test_extreme_square();
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_APPEND, COORD_MIN, COORD_MIN);
    send_item(OP_APPEND, COORD_MAX, COORD_MIN);
    send_item(OP_APPEND, COORD_MAX, COORD_MAX);
    send_item(OP_APPEND, COORD_MIN, COORD_MAX);
    send_item(OP_QUERY, 0, 0);
    send_item(OP_QUERY, COORD_MIN, 0);
    send_item(OP_QUERY, COORD_MAX, 0);
    send_item(OP_QUERY, 0, COORD_MAX);
    send_item(OP_QUERY, COORD_MIN, COORD_MIN);
    send_item(OP_UNUSED, COORD_MAX, COORD_MIN);
  endtask

  // A triangle with a horizontal base: queries at the base, the apex and exactly on a side.
  task automatic test_edge_cases();
    send_item(OP_CLEAR, 0, 0);
    send_item(OP_APPEND, 0, 0);
    send_item(OP_APPEND, 100, 0);
    send_item(OP_APPEND, 50, 100);
    send_item(OP_QUERY, 50, 0);
    send_item(OP_QUERY, 50, 100);
    send_item(OP_QUERY, 25, 50);
    send_item(OP_QUERY, 26, 50);
    send_item(OP_QUERY, -1, 50);
  endtask

  task automatic test_store_full();
    int k;
    send_item(OP_CLEAR, 0, 0);
    for (k = 0; k < MAX_VERTICES; k++) send_item(OP_APPEND, near_coord(0, 5000),
                                                 near_coord(0, 5000));
    for (k = 0; k < 3; k++) send_item(OP_APPEND, coord_t'($urandom), coord_t'($urandom));
    for (k = 0; k < 4; k++) send_item(OP_QUERY, near_coord(0, 4000), near_coord(0, 4000));
    send_item(OP_UNUSED, 0, 0);
    send_item(OP_CLEAR, 0, 0);
  endtask

  // Random polygons with queries at and near their vertices, mixed with stale stores and stray codes.
  task automatic test_random_polygons();
    int     n_vert, n_query, span, k, pick;
    coord_t cx, cy, qx, qy;
    coord_t vx[$];
    coord_t vy[$];
    while (random_items < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 8) begin
        send_item(OP_CLEAR, coord_t'($urandom), coord_t'($urandom));
        random_items++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) n_vert = $urandom_range(1, 8);
      else if (pick < 95) n_vert = $urandom_range(9, 40);
      else n_vert = $urandom_range(41, 200);
      case ($urandom_range(0, 3))
        0: span = 16;
        1: span = 1000;
        2: span = 100000;
        default: span = 0;
      endcase
      cx = coord_t'($urandom);
      cy = coord_t'($urandom);
      vx.delete();
      vy.delete();
      for (k = 0; k < n_vert; k++) begin
        if (span == 0) begin
          vx.push_back(coord_t'($urandom));
          vy.push_back(coord_t'($urandom));
        end else begin
          vx.push_back(near_coord(cx, span));
          vy.push_back(near_coord(cy, span));
        end
        send_item(OP_APPEND, vx[k], vy[k]);
        random_items++;
        if ($urandom_range(0, 30) == 0) send_item(OP_UNUSED, coord_t'($urandom),
                                                  coord_t'($urandom));
      end
      n_query = $urandom_range(1, 8);
      for (k = 0; k < n_query; k++) begin
        pick = $urandom_range(0, n_vert - 1);
        case ($urandom_range(0, 4))
          0, 1: begin
            qx = vx[pick];
            qy = vy[pick];
          end
          2: begin
            qx = vx[pick];
            qy = (span == 0) ? coord_t'($urandom) : near_coord(cy, span);
          end
          default: begin
            qx = (span == 0) ? coord_t'($urandom) : near_coord(cx, span);
            qy = (span == 0) ? coord_t'($urandom) : near_coord(cy, span);
          end
        endcase
        send_item(OP_QUERY, qx, qy);
        random_items++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // The receiver periodically picks a new stall pattern at random from four modes.
  int       rx_tick  = 0;
  int       rx_hold  = 0;
  bit       rx_level = 1'b1;
  rx_mode_t rx_mode  = RX_STEADY;

  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_STEADY:  out_ch.ready <= 1'b1;
      RX_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
      RX_PATTERN: out_ch.ready <= (rx_tick % 3 == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_level = !rx_level;
          rx_hold = rx_level ? $urandom_range(1, 4) : $urandom_range(5, 40);
        end
        rx_hold--;
        out_ch.ready <= rx_level;
      end
    endcase
  end

  // Each result transfer is matched against the oldest outstanding verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: inside_res %0b status %0b vertex_total %0d",
               out_ch.inside_res, out_ch.status, out_ch.vertex_total);
        failures++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_ch.inside_res !== want.inside_res) begin
          $error("result %0d inside_res: expected %0b, actual %0b", results_checked,
                 want.inside_res, out_ch.inside_res);
          failures++;
        end
        if (out_ch.status !== want.status) begin
          $error("result %0d status: expected %0b, actual %0b", results_checked,
                 want.status, out_ch.status);
          failures++;
        end
        if (out_ch.vertex_total !== want.vertex_total) begin
          $error("result %0d vertex_total: expected %0d, actual %0d", results_checked,
                 want.vertex_total, out_ch.vertex_total);
          failures++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               expected_verdicts.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_CLEAR;
    in_ch.coord_x   = '0;
    in_ch.coord_y   = '0;
    out_ch.ready    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sparse_store();
    test_extreme_square();
    test_edge_cases();
    test_store_full();
    test_random_polygons();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d in the random polygon phase) and checked %0d results,",
             items_sent, random_items, results_checked);
    $display("covering empty and full stores, full-range edges and on-edge queries.");
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
